@@ hdl/cpse_pkg.sv @@
// -----------------------------------------------------------------------------
// cpse_pkg
// Shared types and constants for the convex polygon span engine.
// -----------------------------------------------------------------------------
`default_nettype none

package cpse_pkg;

   localparam int MAX_V = 16;
   localparam int CB    = 12;
   localparam int IW    = $clog2(MAX_V);
   localparam int NW_C  = IW + 1;
   localparam int MW    = CB + 2;
   localparam int PW    = 2 * MW;
   localparam int AW    = 2 * CB + IW + 2;
   localparam int NW    = 2 * CB + 2;
   localparam int LW    = NW + 1;
   localparam int DCW   = $clog2(NW);

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_CLOSE = 3'd1,
      OP_TEST  = 3'd2,
      OP_SPAN  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_NOPOLY = 2'd2
   } status_type;

endpackage

`default_nettype wire

@@ hdl/cpse_if.sv @@
// -----------------------------------------------------------------------------
// cpse_req_if / cpse_rsp_if
// Valid/ready channels carrying request and response beats.
// -----------------------------------------------------------------------------
`default_nettype none

interface cpse_req_if import cpse_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [2:0]    operation;
   logic [CB-1:0] coord_x;
   logic [CB-1:0] coord_y;
   modport source (output valid, operation, coord_x, coord_y, input ready);
   modport sink   (input valid, operation, coord_x, coord_y, output ready);
endinterface

interface cpse_rsp_if import cpse_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [1:0]    status;
   logic          inside_res;
   logic [CB-1:0] left_x;
   logic [CB-1:0] right_x;
   logic [CB-1:0] low_y;
   logic [CB-1:0] high_y;
   logic          was_reversed;
   modport source (output valid, status, inside_res, left_x, right_x, low_y, high_y,
                   was_reversed, input ready);
   modport sink   (input valid, status, inside_res, left_x, right_x, low_y, high_y,
                   was_reversed, output ready);
endinterface

`default_nettype wire

@@ hdl/convex_polygon_span_engine.sv @@
// -----------------------------------------------------------------------------
// convex_polygon_span_engine
// Convex polygon store with close, point test and row span over a shared
// multiplier, accumulator and serial divider.
// -----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | operation, coord_x, coord_y
//  rsp     | out | valid/ready | status, inside_res, left_x, right_x, low_y,
//          |     |             | high_y, was_reversed
//
//  add, clear and rejected beats go straight from idle to the response state
//  close: per edge RDP to M3, NXT; when reversed, per swapped pair SWA to SWC
//  test: per edge RDP to M6, NXT; span: RDP to M5, 25-step divider, DEND, NXT
//  req.ready is high only when idle; a held response stalls the engine
//  synchronous reset clears control state; vertex store has no reset
// -----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_span_engine import cpse_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cpse_req_if.sink   req,
   cpse_rsp_if.source rsp
);

   typedef enum logic [16:0] {
      S_IDLE = 17'h00001, S_RDP  = 17'h00002, S_RDQ  = 17'h00004, S_M1   = 17'h00008,
      S_M2   = 17'h00010, S_M3   = 17'h00020, S_M4   = 17'h00040, S_M5   = 17'h00080,
      S_M6   = 17'h00100, S_DIV  = 17'h00200, S_DEND = 17'h00400, S_NXT  = 17'h00800,
      S_SWA  = 17'h01000, S_SWB  = 17'h02000, S_SWC  = 17'h04000, S_DONE = 17'h08000,
      S_RESP = 17'h10000
   } state_type;

   localparam logic [CB-1:0] CMAX = {CB{1'b1}};

   state_type state_ff, state_in;

   logic [2*CB-1:0] store_ff [MAX_V];
   logic [NW_C-1:0] cnt_ff;
   logic            closed_ff, rev_ff;
   logic [CB-1:0]   bxl_ff, bxh_ff, byl_ff, byh_ff;

   logic [2:0]      op_ff;
   logic [CB-1:0]   x_ff, y_ff;
   logic [IW-1:0]   idx_ff, j_ff;
   logic [CB-1:0]   px_ff, py_ff, qx_ff, qy_ff;
   logic [2*CB-1:0] tmp_ff;
   logic signed [PW-1:0] mul_ff;
   logic signed [AW-1:0] acc_ff, area_ff;
   logic signed [LW-1:0] left_ff, right_ff;
   logic            inpoly_ff;
   logic [NW-2:0]   quo_ff;
   logic [CB:0]     rem_ff;
   logic [CB-1:0]   dv_ff;
   logic            neg_ff;
   logic [DCW-1:0]  dcnt_ff;

   logic [1:0]      st_ff;
   logic            ins_ff, rv_ff;
   logic [CB-1:0]   lx_ff, rx_ff, ly_ff, hy_ff;

   logic [IW-1:0]   pidx, rd_addr, cnt_last;
   logic [2*CB-1:0] rd_data;
   logic [CB-1:0]   rdx, rdy;
   logic signed [CB:0]   a_val, b_val;
   logic signed [MW-1:0] ma, mb;
   logic signed [PW-1:0] mul_in;
   logic signed [AW-1:0] prod_w, c_w, s_w, nsum, nabs;
   logic [CB:0]     r2;
   logic signed [LW-1:0] xi;
   logic            accepted;

   function automatic logic [CB-1:0] sat(input logic signed [LW-1:0] v);
      if (v < 0) return '0;
      if (v > $signed({{(LW-CB){1'b0}}, CMAX})) return CMAX;
      return v[CB-1:0];
   endfunction

   assign cnt_last = IW'(cnt_ff - 1'b1);
   assign pidx     = (idx_ff == '0) ? cnt_last : IW'(idx_ff - 1'b1);
   assign rd_addr  = (state_ff == S_RDP) ? pidx : (state_ff == S_SWB) ? j_ff : idx_ff;
   assign rd_data  = store_ff[rd_addr];
   assign rdx      = rd_data[2*CB-1:CB];
   assign rdy      = rd_data[CB-1:0];
   assign a_val    = $signed({1'b0, py_ff}) - $signed({1'b0, qy_ff});
   assign b_val    = $signed({1'b0, qx_ff}) - $signed({1'b0, px_ff});
   assign prod_w   = AW'(mul_ff);
   assign c_w      = acc_ff - prod_w;
   assign s_w      = acc_ff + prod_w;
   assign nsum     = -prod_w - acc_ff;
   assign nabs     = (nsum < 0) ? -nsum : nsum;
   assign r2       = {rem_ff[CB-1:0], quo_ff[NW-2]};
   assign xi       = neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff});
   assign accepted = req.valid && req.ready;

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         S_M1: begin
            ma = $signed({2'b0, px_ff}); mb = $signed({2'b0, qy_ff});
         end
         S_M2: begin
            ma = $signed({2'b0, py_ff}); mb = $signed({2'b0, qx_ff});
         end
         S_M4: begin
            ma = (op_ff == OP_TEST) ? MW'(a_val) : MW'(b_val);
            mb = (op_ff == OP_TEST) ? $signed({2'b0, x_ff}) : $signed({2'b0, y_ff});
         end
         S_M5: begin
            ma = MW'(b_val); mb = $signed({2'b0, y_ff});
         end
         default: begin
            ma = '0; mb = '0;
         end
      endcase
      mul_in = ma * mb;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accepted) begin
               unique case (req.operation) inside
                  OP_CLOSE: state_in = (cnt_ff < 3) ? S_RESP : S_RDP;
                  OP_TEST, OP_SPAN: state_in = (!closed_ff || cnt_ff < 3) ? S_RESP : S_RDP;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RDP:  state_in = S_RDQ;
         S_RDQ:  state_in = S_M1;
         S_M1:   state_in = S_M2;
         S_M2:   state_in = S_M3;
         S_M3: begin
            if (op_ff == OP_CLOSE) state_in = S_NXT;
            else if (op_ff == OP_SPAN && a_val == 0)
               state_in = (py_ff == y_ff) ? S_DONE : S_NXT;
            else state_in = S_M4;
         end
         S_M4:   state_in = S_M5;
         S_M5:   state_in = (op_ff == OP_TEST) ? S_M6 : S_DIV;
         S_M6:   state_in = (s_w > 0) ? S_DONE : S_NXT;
         S_DIV:  state_in = (dcnt_ff == DCW'(NW - 2)) ? S_DEND : S_DIV;
         S_DEND: state_in = S_NXT;
         S_NXT: begin
            if (idx_ff == cnt_last)
               state_in = (op_ff == OP_CLOSE && area_ff > 0) ? S_SWA : S_DONE;
            else state_in = S_RDP;
         end
         S_SWA:  state_in = (idx_ff < j_ff) ? S_SWB : S_DONE;
         S_SWB:  state_in = S_SWC;
         S_SWC:  state_in = S_SWA;
         S_DONE: state_in = S_RESP;
         S_RESP: state_in = rsp.ready ? S_IDLE : S_RESP;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         closed_ff <= 1'b0;
         rev_ff    <= 1'b0;
         bxl_ff    <= '0;
         bxh_ff    <= '0;
         byl_ff    <= '0;
         byh_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (accepted) begin
                  op_ff     <= req.operation;
                  x_ff      <= req.coord_x;
                  y_ff      <= req.coord_y;
                  idx_ff    <= '0;
                  area_ff   <= '0;
                  inpoly_ff <= 1'b1;
                  left_ff   <= LW'($signed({1'b0, bxl_ff}));
                  right_ff  <= LW'($signed({1'b0, bxh_ff}));
                  st_ff     <= ST_OK;
                  ins_ff    <= 1'b0;
                  lx_ff     <= '0;
                  rx_ff     <= '0;
                  ly_ff     <= '0;
                  hy_ff     <= '0;
                  rv_ff     <= 1'b0;
                  unique case (req.operation) inside
                     OP_ADD: begin
                        if (cnt_ff >= NW_C'(MAX_V)) st_ff <= ST_FULL;
                        else begin
                           store_ff[cnt_ff[IW-1:0]] <= {req.coord_x, req.coord_y};
                           cnt_ff    <= cnt_ff + 1'b1;
                           closed_ff <= 1'b0;
                        end
                     end
                     OP_CLOSE: if (cnt_ff < 3) st_ff <= ST_NOPOLY;
                     OP_TEST, OP_SPAN: if (!closed_ff || cnt_ff < 3) st_ff <= ST_NOPOLY;
                     OP_CLEAR: begin
                        cnt_ff    <= '0;
                        closed_ff <= 1'b0;
                        rev_ff    <= 1'b0;
                        bxl_ff    <= '0;
                        bxh_ff    <= '0;
                        byl_ff    <= '0;
                        byh_ff    <= '0;
                     end
                     default: st_ff <= ST_OK;
                  endcase
               end
            end
            S_RDP: begin
               px_ff <= rdx;
               py_ff <= rdy;
            end
            S_RDQ: begin
               qx_ff <= rdx;
               qy_ff <= rdy;
               if (op_ff == OP_CLOSE) begin
                  if (idx_ff == '0 || rdx < bxl_ff) bxl_ff <= rdx;
                  if (idx_ff == '0 || rdx > bxh_ff) bxh_ff <= rdx;
                  if (idx_ff == '0 || rdy < byl_ff) byl_ff <= rdy;
                  if (idx_ff == '0 || rdy > byh_ff) byh_ff <= rdy;
               end
            end
            S_M1: mul_ff <= mul_in;
            S_M2: begin
               acc_ff <= prod_w;
               mul_ff <= mul_in;
            end
            S_M3: begin
               acc_ff <= c_w;
               if (op_ff == OP_CLOSE) area_ff <= area_ff + c_w;
               if (op_ff == OP_SPAN && a_val == 0 && py_ff == y_ff) begin
                  left_ff  <= LW'($signed({1'b0, (px_ff < qx_ff) ? px_ff : qx_ff}));
                  right_ff <= LW'($signed({1'b0, (px_ff < qx_ff) ? qx_ff : px_ff}));
               end
            end
            S_M4: mul_ff <= mul_in;
            S_M5: begin
               if (op_ff == OP_TEST) begin
                  acc_ff <= s_w;
                  mul_ff <= mul_in;
               end else begin
                  quo_ff  <= nabs[NW-2:0];
                  rem_ff  <= '0;
                  dv_ff   <= (a_val < 0) ? CB'(-a_val) : CB'(a_val);
                  neg_ff  <= (nsum < 0) ^ (a_val < 0);
                  dcnt_ff <= '0;
               end
            end
            S_M6: if (s_w > 0) inpoly_ff <= 1'b0;
            S_DIV: begin
               if (r2 >= {1'b0, dv_ff}) begin
                  rem_ff <= r2 - {1'b0, dv_ff};
                  quo_ff <= {quo_ff[NW-3:0], 1'b1};
               end else begin
                  rem_ff <= r2;
                  quo_ff <= {quo_ff[NW-3:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
            end
            S_DEND: begin
               if (py_ff < qy_ff) begin
                  if (left_ff < xi) left_ff <= xi;
               end else begin
                  if (right_ff > xi) right_ff <= xi;
               end
            end
            S_NXT: begin
               if (idx_ff == cnt_last) begin
                  idx_ff <= '0;
                  j_ff   <= cnt_last;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_SWA: tmp_ff <= rd_data;
            S_SWB: store_ff[idx_ff] <= rd_data;
            S_SWC: begin
               store_ff[j_ff] <= tmp_ff;
               idx_ff <= idx_ff + 1'b1;
               j_ff   <= j_ff - 1'b1;
            end
            S_DONE: begin
               unique case (op_ff)
                  OP_CLOSE: begin
                     closed_ff <= 1'b1;
                     rev_ff    <= area_ff > 0;
                     rv_ff     <= area_ff > 0;
                     lx_ff     <= bxl_ff;
                     rx_ff     <= bxh_ff;
                     ly_ff     <= byl_ff;
                     hy_ff     <= byh_ff;
                  end
                  OP_TEST: ins_ff <= inpoly_ff;
                  default: begin
                     lx_ff <= sat(left_ff);
                     rx_ff <= sat(right_ff);
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = (state_ff == S_RESP);
   assign rsp.status       = st_ff;
   assign rsp.inside_res   = ins_ff;
   assign rsp.left_x       = lx_ff;
   assign rsp.right_x      = rx_ff;
   assign rsp.low_y        = ly_ff;
   assign rsp.high_y       = hy_ff;
   assign rsp.was_reversed = rv_ff;

   a_busy_when_resp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready during response");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW_C'(MAX_V)) else $error("vertex count overflow");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("ready after accept");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

endmodule

`default_nettype wire
